// File: src/mfh_pkg.sv
// shared constants and types of the fifo mutex with direct handoff
package mfh_pkg;

  // number of waiter slots and significant id bits
  localparam int QueueDepth = 16;
  localparam int IdBits     = 8;

  // widths of the fixed stream fields
  localparam int IdFieldW  = 8;
  localparam int StatusW   = 3;

  // derived widths
  localparam int IdW   = (IdBits < IdFieldW) ? IdBits : IdFieldW;
  localparam int PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW  = $clog2(QueueDepth + 1);

  // packed stream widths
  localparam int InDataW  = 8;
  localparam int InUserW  = 8;
  localparam int OutDataW = 24;
  localparam int OutUserW = 8;

  typedef logic [IdW-1:0]  id_t;
  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  // request operation
  typedef enum logic {
    FUNC_ACQUIRE = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_GRANTED   = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_FREED     = 3'd3,
    ST_HANDOFF   = 3'd4,
    ST_NOT_OWNER = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  // control states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_e;

  // one result transfer
  typedef struct packed {
    status_e             status;
    logic                woken_valid;
    logic [IdFieldW-1:0] woken_id;
    logic                lock_held;
    logic [IdFieldW-1:0] current_owner;
  } result_t;

  // advance a fifo pointer with wrap
  function automatic ptr_t next_ptr(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

// File: src/mfh_waiter_ram.sv
// waiter queue storage: one write port, one registered read port
module mfh_waiter_ram #(
  parameter int Depth = 16,
  parameter int Width = 8,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/mutex_fifo_handoff_unit.sv
// top level: lock state, waiter queue control and result register
//
// One lock arbitrated among requesters known by an id. Each request transfer
// (acquire or release) yields exactly one result transfer reporting the
// status and the lock state afterwards. A new request can be taken every
// cycle while results are consumed and no handoff is in progress; a release
// that hands the lock to a waiter holds off new requests while the head
// waiter is read from the registered read port of the queue RAM. Waiters
// are served strictly in arrival order; an acquire against a full queue is
// dropped with a queue-full status. Bits of the id above the significant
// width are ignored.
module mutex_fifo_handoff_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mfh_pkg::InDataW-1:0]   s_axis_tdata,  // [7:0] requester_id
  input  logic [mfh_pkg::InUserW-1:0]   s_axis_tuser,  // [0] func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] woken_valid, [8:1] woken_id, [9] lock_held, [17:10] current_owner
  output logic [mfh_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [mfh_pkg::OutUserW-1:0]  m_axis_tuser   // [2:0] status
);

  mfh_pkg::state_e state_q, state_d;
  logic            held_q, held_d;
  mfh_pkg::id_t    owner_q, owner_d;
  mfh_pkg::ptr_t   head_q, head_d;
  mfh_pkg::ptr_t   tail_q, tail_d;
  mfh_pkg::cnt_t   count_q, count_d;

  logic             out_valid_q, out_valid_d;
  mfh_pkg::result_t out_q, out_d;

  logic            in_xfer;
  logic            func;
  mfh_pkg::id_t    req_id;
  logic            is_owner;
  logic            ram_we, ram_re;
  mfh_pkg::id_t    ram_rdata;

  // request decode
  assign func     = s_axis_tuser[0];
  assign req_id   = s_axis_tdata[mfh_pkg::IdW-1:0];
  assign is_owner = held_q && (owner_q == req_id);

  assign s_axis_tready = (state_q == mfh_pkg::S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // waiter queue storage
  mfh_waiter_ram #(
    .Depth (mfh_pkg::QueueDepth),
    .Width (mfh_pkg::IdW)
  ) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (req_id),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // request handling and result formation
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    owner_d     = owner_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;

    unique case (state_q)
      mfh_pkg::S_IDLE: begin
        if (in_xfer) begin
          out_d.woken_valid = 1'b0;
          out_d.woken_id    = '0;
          if (func == mfh_pkg::FUNC_ACQUIRE) begin
            if (is_owner) begin
              out_d.status = mfh_pkg::ST_ALREADY;
            end else if (!held_q) begin
              held_d       = 1'b1;
              owner_d      = req_id;
              out_d.status = mfh_pkg::ST_GRANTED;
            end else if (count_q == mfh_pkg::cnt_t'(mfh_pkg::QueueDepth)) begin
              out_d.status = mfh_pkg::ST_FULL;
            end else begin
              ram_we       = 1'b1;
              tail_d       = mfh_pkg::next_ptr(tail_q);
              count_d      = count_q + mfh_pkg::cnt_t'(1);
              out_d.status = mfh_pkg::ST_QUEUED;
            end
          end else begin
            if (!is_owner) begin
              out_d.status = mfh_pkg::ST_NOT_OWNER;
            end else if (count_q != '0) begin
              ram_re  = 1'b1;
              state_d = mfh_pkg::S_POP;
            end else begin
              held_d       = 1'b0;
              owner_d      = '0;
              out_d.status = mfh_pkg::ST_FREED;
            end
          end
          out_d.lock_held     = held_d;
          out_d.current_owner = held_d ? mfh_pkg::IdFieldW'(owner_d) : '0;
          // a handoff result is formed once the head waiter is read
          if (state_d == mfh_pkg::S_IDLE) begin
            out_valid_d = 1'b1;
          end
        end
      end
      mfh_pkg::S_POP: begin
        owner_d             = ram_rdata;
        head_d              = mfh_pkg::next_ptr(head_q);
        count_d             = count_q - mfh_pkg::cnt_t'(1);
        out_d.status        = mfh_pkg::ST_HANDOFF;
        out_d.woken_valid   = 1'b1;
        out_d.woken_id      = mfh_pkg::IdFieldW'(ram_rdata);
        out_d.lock_held     = 1'b1;
        out_d.current_owner = mfh_pkg::IdFieldW'(ram_rdata);
        out_valid_d         = 1'b1;
        state_d             = mfh_pkg::S_IDLE;
      end
      default: begin
        state_d = mfh_pkg::S_IDLE;
      end
    endcase
  end

  // control and lock state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfh_pkg::S_IDLE;
      held_q      <= 1'b0;
      owner_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      owner_q     <= owner_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.current_owner, out_q.lock_held,
                          out_q.woken_id, out_q.woken_valid};
  assign m_axis_tuser  = {5'd0, out_q.status};

  // queue occupancy never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mfh_pkg::cnt_t'(mfh_pkg::QueueDepth))
    else $error("waiter count above queue depth");

  // waiters only exist while the lock is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> held_q)
    else $error("waiters queued on a free lock");

  // a pop cycle follows a release by the owner with waiters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfh_pkg::S_POP) |-> $past(in_xfer) && held_q && (count_q != '0))
    else $error("pop state without a handoff release");

  // the result register is free when the handoff result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfh_pkg::S_POP) |-> !out_valid_q)
    else $error("handoff result would overwrite a pending result");

endmodule
